[rtl/core/text_mode_terminal_writer_macros.svh]
// Assertion macros shared by the console writer RTL.
`ifndef TEXT_MODE_TERMINAL_WRITER_MACROS_SVH
`define TEXT_MODE_TERMINAL_WRITER_MACROS_SVH

`ifndef NO_ASSERTIONS

// ante holds -> cons holds in the same cycle
`define TMTW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tmtw assertion failed");

// ante holds -> cons holds in the next cycle
`define TMTW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tmtw assertion failed");

`else

`define TMTW_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TMTW_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/core/tmtw_pkg.sv]
`default_nettype none

package tmtw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;

    localparam int COL_W   = $clog2(COLUMNS);
    localparam int ROW_W   = (ROWS > 2) ? $clog2(ROWS) : 1;
    localparam int ADDR_W  = $clog2(CELL_COUNT);
    localparam int ADDR1_W = ADDR_W + 1;
    localparam int CNT_W   = $clog2(CELL_COUNT + 1);
    localparam int POS_W   = 11;
    localparam int IDX_W   = 11;

    localparam logic [7:0] ATTR_RESET = 8'h07;
    localparam logic [7:0] CH_NL      = 8'd10;
    localparam logic [7:0] CH_CR      = 8'd13;
    localparam logic [7:0] CH_BS      = 8'd8;
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    typedef enum logic [1:0] {
        ACT_PUT   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } tmtw_action_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_STORE,
        OP_NEWLINE,
        OP_CR,
        OP_BS,
        OP_CLEAR,
        OP_INIT,
        OP_FILL,
        OP_READ,
        OP_RESULT
    } tmtw_op_t;

    typedef struct packed {
        tmtw_op_t op;
        logic     use_space;
    } tmtw_cmd_t;

    typedef struct packed {
        tmtw_action_t act;
        logic         is_nl;
        logic         is_cr;
        logic         is_bs;
        logic         is_tab;
        logic         col_last;
        logic         row_last;
        logic         fill_last;
        logic [2:0]   tab_n;
    } tmtw_status_t;

    typedef struct packed {
        logic [1:0]       action;
        logic [7:0]       char_code;
        logic [IDX_W-1:0] cell_index;
    } tmtw_in_t;

    typedef struct packed {
        logic [POS_W-1:0] cursor_pos;
        logic             cursor_written;
        logic [15:0]      cell_data;
    } tmtw_out_t;

endpackage

`default_nettype wire

[rtl/core/tmtw_dp.sv]
`default_nettype none

`include "text_mode_terminal_writer_macros.svh"

module tmtw_dp
    import tmtw_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire tmtw_cmd_t    cmd,
    output tmtw_status_t      status,
    input  wire tmtw_in_t     in_data,
    output tmtw_out_t         out_data,
    input  wire logic         cfg_wr_en,
    input  wire logic [7:0]   cfg_wr_data
);

    logic [15:0] cell_mem [CELL_COUNT];

    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [ADDR_W-1:0] fill_ptr_reg, fill_ptr_next;
    logic [CNT_W-1:0]  fill_cnt_reg, fill_cnt_next;
    logic [7:0]        attr_reg;

    logic [15:0]       fill_val_reg, fill_val_next;
    tmtw_in_t          item_reg;
    tmtw_out_t         out_reg, out_next;
    logic [15:0]       rd_data_reg;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [15:0]       mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    logic [ADDR_W-1:0]  lin;
    logic [ADDR1_W-1:0] base_sum;
    logic [ADDR_W-1:0]  base_step;
    logic [15:0]        blank;
    logic               col_last;
    logic               row_last;
    logic               adv_row;
    logic               idx_ok;

    function automatic logic [ADDR_W-1:0] phys_addr(
        input logic [ADDR_W-1:0] a,
        input logic [ADDR_W-1:0] b
    );
        logic [ADDR1_W-1:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            if (s >= ADDR1_W'(CELL_COUNT))
            begin
                s = s - ADDR1_W'(CELL_COUNT);
            end
            return s[ADDR_W-1:0];
        end
    endfunction

    assign lin       = ADDR_W'(row_reg) * ADDR_W'(COLUMNS) + ADDR_W'(col_reg);
    assign base_sum  = {1'b0, base_reg} + ADDR1_W'(COLUMNS);
    assign base_step = (base_sum >= ADDR1_W'(CELL_COUNT)) ? '0 : base_sum[ADDR_W-1:0];
    assign blank     = {attr_reg, CH_SPACE};
    assign col_last  = (col_reg == COL_W'(COLUMNS - 1));
    assign row_last  = (row_reg == ROW_W'(ROWS - 1));
    assign idx_ok    = (32'(item_reg.cell_index) < CELL_COUNT);

    always_comb
    begin
        status.act       = tmtw_action_t'(item_reg.action);
        status.is_nl     = (item_reg.char_code == CH_NL);
        status.is_cr     = (item_reg.char_code == CH_CR);
        status.is_bs     = (item_reg.char_code == CH_BS);
        status.is_tab    = (item_reg.char_code == CH_TAB);
        status.col_last  = col_last;
        status.row_last  = row_last;
        status.fill_last = (fill_cnt_reg == CNT_W'(1));
        status.tab_n     = 3'd4 - {1'b0, col_reg[1:0]};
    end

    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        base_next     = base_reg;
        fill_ptr_next = fill_ptr_reg;
        fill_cnt_next = fill_cnt_reg;
        fill_val_next = fill_val_reg;
        out_next      = out_reg;
        mem_we        = 1'b0;
        mem_waddr     = phys_addr(lin, base_reg);
        mem_wdata     = blank;
        mem_re        = 1'b0;
        mem_raddr     = phys_addr(ADDR_W'(item_reg.cell_index), base_reg);
        adv_row       = 1'b0;

        case (cmd.op)
            OP_STORE:
            begin
                mem_we    = 1'b1;
                mem_wdata = {attr_reg, cmd.use_space ? CH_SPACE : item_reg.char_code};
                if (col_last)
                begin
                    adv_row = 1'b1;
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            OP_NEWLINE:
            begin
                adv_row = 1'b1;
            end
            OP_CR:
            begin
                col_next = '0;
            end
            OP_BS:
            begin
                if (col_reg != '0)
                begin
                    col_next  = col_reg - 1'b1;
                    mem_we    = 1'b1;
                    mem_waddr = phys_addr(lin - 1'b1, base_reg);
                end
            end
            OP_CLEAR:
            begin
                col_next      = '0;
                row_next      = '0;
                base_next     = '0;
                fill_ptr_next = '0;
                fill_cnt_next = CNT_W'(CELL_COUNT);
                fill_val_next = blank;
            end
            OP_INIT:
            begin
                base_next     = '0;
                fill_ptr_next = '0;
                fill_cnt_next = CNT_W'(CELL_COUNT);
                fill_val_next = '0;
            end
            OP_FILL:
            begin
                mem_we        = 1'b1;
                mem_waddr     = fill_ptr_reg;
                mem_wdata     = fill_val_reg;
                fill_ptr_next = fill_ptr_reg + 1'b1;
                fill_cnt_next = fill_cnt_reg - 1'b1;
            end
            OP_READ:
            begin
                mem_re = 1'b1;
            end
            OP_RESULT:
            begin
                out_next.cursor_pos     = POS_W'(lin);
                out_next.cursor_written = (status.act == ACT_PUT) && !status.is_cr;
                out_next.cell_data      = (status.act == ACT_READ && idx_ok) ? rd_data_reg : '0;
            end
            default:
            begin
            end
        endcase

        // row advance, scrolling by rotating the row base
        if (adv_row)
        begin
            col_next = '0;
            if (row_last)
            begin
                fill_ptr_next = base_reg;
                fill_cnt_next = CNT_W'(COLUMNS);
                fill_val_next = blank;
                base_next     = base_step;
            end
            else
            begin
                row_next = row_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            base_reg     <= '0;
            fill_ptr_reg <= '0;
            fill_cnt_reg <= '0;
            attr_reg     <= ATTR_RESET;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            base_reg     <= base_next;
            fill_ptr_reg <= fill_ptr_next;
            fill_cnt_reg <= fill_cnt_next;
            if (cfg_wr_en)
            begin
                attr_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fill_val_reg <= fill_val_next;
        out_reg      <= out_next;
        if (cmd.op == OP_LOAD)
        begin
            item_reg <= in_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cell_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= cell_mem[mem_raddr];
        end
    end

    assign out_data = out_reg;

    `TMTW_ASSERT_IMP(a_col_range, clk, rst_n, 1'b1, col_reg <= COL_W'(COLUMNS - 1))
    `TMTW_ASSERT_IMP(a_row_range, clk, rst_n, 1'b1, row_reg <= ROW_W'(ROWS - 1))
    `TMTW_ASSERT_IMP(a_base_range, clk, rst_n, 1'b1,
        32'(base_reg) <= CELL_COUNT - COLUMNS)
    `TMTW_ASSERT_NXT(a_scroll_fill, clk, rst_n, adv_row && row_last,
        fill_cnt_reg == CNT_W'(COLUMNS))

endmodule

`default_nettype wire

[rtl/core/tmtw_ctrl.sv]
`default_nettype none

`include "text_mode_terminal_writer_macros.svh"

module tmtw_ctrl
    import tmtw_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  wire logic         out_ready,
    output tmtw_cmd_t         cmd,
    input  wire tmtw_status_t status
);

    typedef enum logic [2:0] {
        S_INIT,
        S_INIT_FILL,
        S_IDLE,
        S_DISPATCH,
        S_TAB,
        S_FILL,
        S_DONE
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] tab_cnt_reg, tab_cnt_next;
    logic       out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        tab_cnt_next   = tab_cnt_reg;
        out_valid_next = out_valid_reg;
        cmd.op         = OP_NOP;
        cmd.use_space  = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_INIT:
            begin
                cmd.op     = OP_INIT;
                state_next = S_INIT_FILL;
            end
            S_INIT_FILL:
            begin
                cmd.op = OP_FILL;
                if (status.fill_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op       = OP_LOAD;
                    tab_cnt_next = '0;
                    state_next   = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (status.act)
                    ACT_PUT:
                    begin
                        if (status.is_nl)
                        begin
                            cmd.op     = OP_NEWLINE;
                            state_next = status.row_last ? S_FILL : S_DONE;
                        end
                        else if (status.is_cr)
                        begin
                            cmd.op     = OP_CR;
                            state_next = S_DONE;
                        end
                        else if (status.is_bs)
                        begin
                            cmd.op     = OP_BS;
                            state_next = S_DONE;
                        end
                        else if (status.is_tab)
                        begin
                            tab_cnt_next = status.tab_n;
                            state_next   = S_TAB;
                        end
                        else
                        begin
                            cmd.op     = OP_STORE;
                            state_next = (status.col_last && status.row_last) ? S_FILL : S_DONE;
                        end
                    end
                    ACT_CLEAR:
                    begin
                        cmd.op     = OP_CLEAR;
                        state_next = S_FILL;
                    end
                    ACT_READ:
                    begin
                        cmd.op     = OP_READ;
                        state_next = S_DONE;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_TAB:
            begin
                cmd.op        = OP_STORE;
                cmd.use_space = 1'b1;
                tab_cnt_next  = tab_cnt_reg - 1'b1;
                if (status.col_last && status.row_last)
                begin
                    state_next = S_FILL;
                end
                else if (tab_cnt_reg == 3'd1)
                begin
                    state_next = S_DONE;
                end
            end
            S_FILL:
            begin
                cmd.op = OP_FILL;
                if (status.fill_last)
                begin
                    state_next = (tab_cnt_reg != '0) ? S_TAB : S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = OP_RESULT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            tab_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tab_cnt_reg   <= tab_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `TMTW_ASSERT_NXT(a_accept_dispatch, clk, rst_n, in_valid && in_ready,
        state_reg == S_DISPATCH)
    `TMTW_ASSERT_IMP(a_tab_count, clk, rst_n, state_reg == S_TAB, tab_cnt_reg != '0)
    `TMTW_ASSERT_NXT(a_fill_exit, clk, rst_n, state_reg == S_FILL && status.fill_last,
        state_reg == S_TAB || state_reg == S_DONE)
    `TMTW_ASSERT_NXT(a_result_load, clk, rst_n, cmd.op == OP_RESULT,
        out_valid_reg && state_reg == S_IDLE)

endmodule

`default_nettype wire

[rtl/core/text_mode_terminal_writer.sv]
// Text-mode console writer, 80 x 25 cells of {attribute, character}.
// Input channel (in_valid/in_ready/in_data): one action per transfer:
//   put character, clear screen, or read one cell.
// Output channel (out_valid/out_ready/out_data): exactly one result per
//   action: cursor position after the action, cursor-update flag, cell data.
// Config: cfg_wr_en/cfg_wr_data write the text attribute.
// One action is in flight at a time. A tab writes one space per column up
// to the next tab stop, a multiple of 4. A scroll blanks the bottom row
// one cell per cycle through the single write port of the cell RAM; rows
// are rotated by a base offset, not copied. Clear blanks all 2000 cells,
// one cell per cycle.
// At reset the cell RAM is zeroed by a clearing pass; in_ready stays low
// until it ends. Config writes are taken during that pass.
// The result sits in an output register; a stalled receiver holds it there
// while the next action is taken and worked on, which then waits in its
// final state until the register frees.
`default_nettype none

module text_mode_terminal_writer
    import tmtw_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire tmtw_in_t   in_data,
    output logic            out_valid,
    input  wire logic       out_ready,
    output tmtw_out_t       out_data,
    input  wire logic       cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data
);

    tmtw_cmd_t    cmd;
    tmtw_status_t status;

    tmtw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    tmtw_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .in_data     (in_data),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

endmodule

`default_nettype wire

[tb/sv/text_mode_terminal_writer_tb.sv]
`timescale 1ns / 1ps

module text_mode_terminal_writer_tb;
    import tmtw_pkg::*;

    localparam int     IDLE_PCT    = 27;
    localparam longint CYCLE_LIMIT = 4_000_000;
    localparam int     TAIL_CYCLES = 200;

    class console_scoreboard;
        logic [15:0] cells [CELL_COUNT];
        int          col;
        int          row;
        logic [7:0]  attr;
        tmtw_out_t   pending [$];
        int          errors;
        int          checked;
        int          scrolls;
        int          clears;
        int          reads;

        function new();
            foreach (cells[i])
            begin
                cells[i] = '0;
            end
            col     = 0;
            row     = 0;
            attr    = ATTR_RESET;
            errors  = 0;
            checked = 0;
            scrolls = 0;
            clears  = 0;
            reads   = 0;
        endfunction

        function logic [15:0] blank();
            return {attr, CH_SPACE};
        endfunction

        function int cursor_index();
            return row * COLUMNS + col;
        endfunction

        function void line_feed();
            col = 0;
            row++;
            if (row >= ROWS)
            begin
                for (int i = 0; i < CELL_COUNT - COLUMNS; i++)
                begin
                    cells[i] = cells[i + COLUMNS];
                end
                for (int x = 0; x < COLUMNS; x++)
                begin
                    cells[(ROWS - 1) * COLUMNS + x] = blank();
                end
                row = ROWS - 1;
                scrolls++;
            end
        endfunction

        function void put_glyph(logic [7:0] ch);
            cells[cursor_index()] = {attr, ch};
            col++;
            if (col >= COLUMNS)
            begin
                line_feed();
            end
        endfunction

        function void note_action(tmtw_in_t it);
            tmtw_out_t res;
            int        n;
            res = '0;
            case (tmtw_action_t'(it.action))
                ACT_PUT:
                begin
                    res.cursor_written = 1'b1;
                    if (it.char_code == CH_NL)
                    begin
                        line_feed();
                    end
                    else if (it.char_code == CH_CR)
                    begin
                        col = 0;
                        res.cursor_written = 1'b0;
                    end
                    else if (it.char_code == CH_BS)
                    begin
                        if (col > 0)
                        begin
                            col--;
                            cells[cursor_index()] = blank();
                        end
                    end
                    else if (it.char_code == CH_TAB)
                    begin
                        n = 4 - (col % 4);
                        repeat (n) put_glyph(CH_SPACE);
                    end
                    else
                    begin
                        put_glyph(it.char_code);
                    end
                end
                ACT_CLEAR:
                begin
                    foreach (cells[i])
                    begin
                        cells[i] = blank();
                    end
                    col = 0;
                    row = 0;
                    clears++;
                end
                ACT_READ:
                begin
                    reads++;
                    if (it.cell_index < CELL_COUNT)
                    begin
                        res.cell_data = cells[it.cell_index];
                    end
                end
                default:
                begin
                end
            endcase
            res.cursor_pos = POS_W'(cursor_index());
            pending.push_back(res);
        endfunction

        function void check_result(tmtw_out_t got);
            tmtw_out_t want;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing pending, got %h", $time, got);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.cursor_pos !== want.cursor_pos)
            begin
                errors++;
                $display("%0t: cursor_pos exp %0d got %0d", $time,
                         want.cursor_pos, got.cursor_pos);
            end
            if (got.cursor_written !== want.cursor_written)
            begin
                errors++;
                $display("%0t: cursor_written exp %0b got %0b", $time,
                         want.cursor_written, got.cursor_written);
            end
            if (got.cell_data !== want.cell_data)
            begin
                errors++;
                $display("%0t: cell_data exp %h got %h", $time,
                         want.cell_data, got.cell_data);
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    tmtw_in_t   in_data;
    logic       out_valid;
    logic       out_ready = 1'b0;
    tmtw_out_t  out_data;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;

    console_scoreboard sb = new();
    bit                no_idle = 1'b0;
    longint            cycles = 0;
    int                items_sent = 0;

    text_mode_terminal_writer u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results pending", $time, sb.pending.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_result(out_data);
        end
    end

    function automatic tmtw_in_t make_item(tmtw_action_t act, logic [7:0] ch, int idx);
        tmtw_in_t it;
        it.action     = act;
        it.char_code  = ch;
        it.cell_index = IDX_W'(idx);
        return it;
    endfunction

    function automatic tmtw_in_t random_item(bit allow_clear);
        tmtw_in_t it;
        int       r;
        int       pos;
        it = make_item(ACT_PUT, 8'($urandom_range(255)), $urandom_range(2047));
        r  = $urandom_range(99);
        if (r < 50)
        begin
        end
        else if (r < 68)
        begin
            it.char_code = CH_NL;
        end
        else if (r < 72)
        begin
            it.char_code = CH_CR;
        end
        else if (r < 78)
        begin
            it.char_code = CH_BS;
        end
        else if (r < 86)
        begin
            it.char_code = CH_TAB;
        end
        else if (r < 96)
        begin
            it.action = ACT_READ;
            if ($urandom_range(1) == 1)
            begin
                pos = sb.cursor_index() - int'($urandom_range(80));
                if (pos < 0)
                begin
                    pos = 0;
                end
                it.cell_index = IDX_W'(pos);
            end
        end
        else if (r < 98)
        begin
            it.action = ACT_NONE;
        end
        else
        begin
            it.action = allow_clear ? ACT_CLEAR : ACT_READ;
        end
        return it;
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_item(input tmtw_in_t it);
        while (!no_idle && ($urandom_range(99) < IDLE_PCT))
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        sb.note_action(it);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic write_attr(input logic [7:0] value);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
        begin
            @(negedge clk);
        end
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        sb.attr = value;
    endtask

    initial
    begin
        logic [7:0] phase_attr [4];
        int         phase_len  [4];
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        phase_attr  = '{8'h00, 8'hFF, 8'($urandom_range(255)), 8'h1E};
        phase_len   = '{150, 150, 100, 100};
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset contents, out of range read, unused action
        send_item(make_item(ACT_READ, 8'h00, 0));
        send_item(make_item(ACT_READ, 8'hFF, CELL_COUNT - 1));
        send_item(make_item(ACT_READ, 8'h00, 2047));
        send_item(make_item(ACT_NONE, 8'hFF, 2047));
        // characters, backspace, return, tab alignment, newline, clear
        send_item(make_item(ACT_PUT, 8'h41, 0));
        send_item(make_item(ACT_PUT, 8'h00, 0));
        send_item(make_item(ACT_PUT, 8'hFF, 2047));
        send_item(make_item(ACT_PUT, CH_BS, 0));
        send_item(make_item(ACT_READ, 8'h00, 2));
        send_item(make_item(ACT_READ, 8'h00, 1));
        send_item(make_item(ACT_PUT, CH_CR, 0));
        send_item(make_item(ACT_PUT, CH_BS, 0));
        send_item(make_item(ACT_PUT, CH_TAB, 0));
        send_item(make_item(ACT_PUT, 8'h78, 0));
        send_item(make_item(ACT_PUT, CH_TAB, 0));
        send_item(make_item(ACT_READ, 8'h00, 4));
        send_item(make_item(ACT_READ, 8'h00, 7));
        send_item(make_item(ACT_PUT, CH_NL, 0));
        send_item(make_item(ACT_CLEAR, 8'h00, 0));
        send_item(make_item(ACT_READ, 8'h00, 0));
        send_item(make_item(ACT_READ, 8'h00, CELL_COUNT - 1));

        for (int ph = 0; ph < 4; ph++)
        begin
            write_attr(phase_attr[ph]);
            no_idle = (ph == 1);
            for (int k = 0; k < phase_len[ph]; k++)
            begin
                send_item(random_item(ph >= 2));
            end
        end
        no_idle  = 1'b0;
        in_valid <= 1'b0;

        while (sb.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d actions, checked %0d results: %0d reads, %0d clears, %0d scrolls",
                 items_sent, sb.checked, sb.reads, sb.clears, sb.scrolls);
        $display("Attributes 07, 00, FF and two others; %0d mismatches", sb.errors);
        if (sb.errors == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
